[hw/rtl/kcc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, operation codes and the queue item type for the k-mer counter.
// Used by every module of the block except kcc_ram; depends on nothing else.
package kcc_pkg;

	localparam int MAX_K       = 8;
	localparam int COUNT_BITS  = 16;
	localparam int WIN_W       = 2 * MAX_K;
	localparam int ADDR_W      = WIN_W;
	localparam int TABLE_DEPTH = 1 << ADDR_W;
	localparam int KCNT_W      = $clog2(MAX_K + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// The queue depth must be a power of two so that the pointers wrap by themselves.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic       REG_KMER_LEN   = 1'b0;
	localparam logic       REG_CANONICAL  = 1'b1;
	localparam logic [3:0] KMER_LEN_RESET = 4'd8;
	localparam logic       CANONICAL_RESET = 1'b1;

	localparam logic FUNC_BASE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_INC  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
	} item_t;

endpackage

[hw/rtl/kcc_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// The read returns the contents from before a write to the same address. No dependencies.
module kcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/kcc_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, base decoding, forward and reverse-complement windows.
// Classifies each transaction into a table operation; depends on kcc_pkg.
module kcc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [3:0]                 cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       func,
	input  logic [7:0]                 base_char,
	input  logic [15:0]                read_addr,
	output logic                       push,
	output kcc_pkg::item_t             push_item,
	input  logic                       push_ready
);

	logic [3:0]                       kmer_len_q;
	logic                             canonical_q;
	logic [kcc_pkg::WIN_W-1:0]        fwd_q;
	logic [kcc_pkg::WIN_W-1:0]        rev_q;
	logic [kcc_pkg::KCNT_W-1:0]       vb_q;

	logic [kcc_pkg::KCNT_W-1:0]       k_eff;
	logic [kcc_pkg::WIN_W-1:0]        mask;
	logic [1:0]                       code;
	logic                             is_base;
	logic [kcc_pkg::WIN_W-1:0]        fwd_n;
	logic [kcc_pkg::WIN_W-1:0]        rev_n;
	logic [kcc_pkg::KCNT_W-1:0]       vb_n;
	logic [kcc_pkg::KCNT_W-1:0]       k_m1;
	logic                             counted;
	logic                             accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;
	assign push     = accept;

	always_comb begin
		if (kmer_len_q == 4'd0) begin
			k_eff = kcc_pkg::KCNT_W'(1);
		end else if (int'(kmer_len_q) > kcc_pkg::MAX_K) begin
			k_eff = kcc_pkg::KCNT_W'(kcc_pkg::MAX_K);
		end else begin
			k_eff = kcc_pkg::KCNT_W'(kmer_len_q);
		end
	end

	always_comb begin
		case (base_char)
			kcc_pkg::CHAR_A: begin code = kcc_pkg::BASE_A; is_base = 1'b1; end
			kcc_pkg::CHAR_C: begin code = kcc_pkg::BASE_C; is_base = 1'b1; end
			kcc_pkg::CHAR_G: begin code = kcc_pkg::BASE_G; is_base = 1'b1; end
			kcc_pkg::CHAR_T: begin code = kcc_pkg::BASE_T; is_base = 1'b1; end
			default: begin code = kcc_pkg::BASE_A; is_base = 1'b0; end
		endcase
	end

	assign k_m1  = k_eff - kcc_pkg::KCNT_W'(1);
	assign mask  = ~({kcc_pkg::WIN_W{1'b1}} << {k_eff, 1'b0});
	assign fwd_n = {fwd_q[kcc_pkg::WIN_W-3:0], code} & mask;
	assign rev_n = ((rev_q & mask) >> 2)
		| (kcc_pkg::WIN_W'(kcc_pkg::BASE_T - code) << {k_m1, 1'b0});
	assign vb_n    = (vb_q < k_eff) ? vb_q + kcc_pkg::KCNT_W'(1) : vb_q;
	assign counted = (vb_n >= k_eff);

	always_comb begin
		push_item.op   = kcc_pkg::OP_NONE;
		push_item.addr = '0;
		if (func == kcc_pkg::FUNC_READ) begin
			push_item.op   = kcc_pkg::OP_READ;
			push_item.addr = kcc_pkg::ADDR_W'(read_addr);
		end else if (is_base && counted) begin
			push_item.op = kcc_pkg::OP_INC;
			if (canonical_q && (rev_n < fwd_n)) begin
				push_item.addr = kcc_pkg::ADDR_W'(rev_n);
			end else begin
				push_item.addr = kcc_pkg::ADDR_W'(fwd_n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q  <= kcc_pkg::KMER_LEN_RESET;
			canonical_q <= kcc_pkg::CANONICAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kcc_pkg::REG_KMER_LEN:  kmer_len_q  <= cfg_data;
				kcc_pkg::REG_CANONICAL: canonical_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rev_q <= '0;
			vb_q  <= '0;
		end else if (accept && func == kcc_pkg::FUNC_BASE) begin
			if (is_base) begin
				fwd_q <= fwd_n;
				rev_q <= rev_n;
				vb_q  <= vb_n;
			end else begin
				fwd_q <= '0;
				rev_q <= '0;
				vb_q  <= '0;
			end
		end
	end

endmodule

[hw/rtl/kcc_queue.sv]
`timescale 1ns / 1ps
// Short first-in first-out queue of table operations between the front and back ends.
// Depends on kcc_pkg for the item type and depth.
module kcc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kcc_pkg::item_t push_item,
	output logic           push_ready,
	input  logic           pop,
	output logic           head_valid,
	output kcc_pkg::item_t head_item
);

	kcc_pkg::item_t              slot_q [kcc_pkg::QDEPTH];
	logic [kcc_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [kcc_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [kcc_pkg::QCNT_W-1:0]  count_q;

	assign push_ready = (count_q != kcc_pkg::QCNT_W'(kcc_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + kcc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + kcc_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + kcc_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - kcc_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/kcc_back.sv]
`timescale 1ns / 1ps
// Back end: count table read-modify-write with write forwarding, clearing pass, result register.
// Depends on kcc_pkg and kcc_ram.
module kcc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  kcc_pkg::item_t head_item,
	output logic           pop,
	output logic           busy,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           kmer_counted,
	output logic [15:0]    kmer_index,
	output logic [15:0]    count_value,
	output logic           saturated
);

	logic                              clr_q;
	logic [kcc_pkg::ADDR_W-1:0]        clr_addr_q;

	logic                              valid_s1;
	logic [1:0]                        op_s1;
	logic [kcc_pkg::ADDR_W-1:0]        addr_s1;

	logic                              lw_valid_q;
	logic [kcc_pkg::ADDR_W-1:0]        lw_addr_q;
	logic [kcc_pkg::COUNT_BITS-1:0]    lw_data_q;

	logic                              out_valid_q;

	logic [kcc_pkg::COUNT_BITS-1:0]    rd_data;
	logic [kcc_pkg::COUNT_BITS-1:0]    old_cnt;
	logic [kcc_pkg::COUNT_BITS-1:0]    new_cnt;
	logic                              sat;
	logic                              adv_s1;
	logic                              upd;
	logic                              ram_we;
	logic [kcc_pkg::ADDR_W-1:0]        ram_waddr;
	logic [kcc_pkg::COUNT_BITS-1:0]    ram_wdata;

	assign busy      = clr_q;
	assign out_valid = out_valid_q;
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign pop       = head_valid && !clr_q && (!valid_s1 || adv_s1);

	assign old_cnt = (lw_valid_q && lw_addr_q == addr_s1) ? lw_data_q : rd_data;
	assign sat     = (old_cnt == kcc_pkg::COUNT_MAX);
	assign new_cnt = sat ? old_cnt : old_cnt + kcc_pkg::COUNT_BITS'(1);
	assign upd     = adv_s1 && (op_s1 == kcc_pkg::OP_INC);

	assign ram_we    = clr_q || upd;
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? '0 : new_cnt;

	kcc_ram #(
		.WIDTH(kcc_pkg::COUNT_BITS),
		.DEPTH(kcc_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop),
		.raddr(head_item.addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + kcc_pkg::ADDR_W'(1);
			if (clr_addr_q == {kcc_pkg::ADDR_W{1'b1}}) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1   <= head_item.op;
			addr_s1 <= head_item.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (upd) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			lw_addr_q <= addr_s1;
			lw_data_q <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			case (op_s1)
				kcc_pkg::OP_INC: begin
					kmer_counted <= 1'b1;
					kmer_index   <= 16'(addr_s1);
					count_value  <= 16'(new_cnt);
					saturated    <= sat;
				end
				kcc_pkg::OP_READ: begin
					kmer_counted <= 1'b0;
					kmer_index   <= '0;
					count_value  <= 16'(old_cnt);
					saturated    <= 1'b0;
				end
				default: begin
					kmer_counted <= 1'b0;
					kmer_index   <= '0;
					count_value  <= '0;
					saturated    <= 1'b0;
				end
			endcase
		end
	end

endmodule

[hw/rtl/kmer_counting_canonical.sv]
`timescale 1ns / 1ps
// Top level of the canonical k-mer counter: front end, operation queue and table back end.
// Depends on kcc_pkg, kcc_front, kcc_queue and kcc_back (which holds kcc_ram).
//
//   Channel   Handshake                Payload
//   input     in_valid / in_ready      func, base_char, read_addr
//   output    out_valid / out_ready    kmer_counted, kmer_index, count_value, saturated
//   config    cfg_we                   cfg_index, cfg_data
//
// While the output is ready, one transaction per cycle is sustained and the count table's
// read-modify-write runs one entry per cycle with forwarding of the last write. Results pass the
// queue, the read stage and the result register. After reset a clearing pass writes zero to all
// 65536 table entries, one per cycle, and in_ready stays low for those cycles. Configuration
// writes are taken at any time. A stalled output fills the four-entry queue before in_ready drops.
module kmer_counting_canonical (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  base_char,
	input  logic [15:0] read_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kmer_counted,
	output logic [15:0] kmer_index,
	output logic [15:0] count_value,
	output logic        saturated
);

	logic           push;
	kcc_pkg::item_t push_item;
	logic           q_ready;
	logic           pop;
	logic           head_valid;
	kcc_pkg::item_t head_item;
	logic           busy;

	kcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.base_char (base_char),
		.read_addr (read_addr),
		.push      (push),
		.push_item (push_item),
		.push_ready(q_ready && !busy)
	);

	kcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.push_ready(q_ready),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	kcc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kmer_counted(kmer_counted),
		.kmer_index  (kmer_index),
		.count_value (count_value),
		.saturated   (saturated)
	);

endmodule

[bench/kmer_counting_canonical_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for kmer_counting_canonical: directed and random read characters,
// table reads and k and mode changes, checked against its own model.
// Depends on kcc_pkg and the kmer_counting_canonical RTL.
module kmer_counting_canonical_tb;

	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] DNA_CHARS [4] = '{kcc_pkg::CHAR_A, kcc_pkg::CHAR_C,
		kcc_pkg::CHAR_G, kcc_pkg::CHAR_T};

	typedef struct {
		logic        fn;
		logic [7:0]  ch;
		logic [15:0] addr;
		bit          hold;
	} char_item_t;

	typedef struct packed {
		logic        counted;
		logic [15:0] index;
		logic [15:0] count;
		logic        sat;
	} kmer_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = kcc_pkg::REG_KMER_LEN;
	logic [3:0]  cfg_data = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = kcc_pkg::FUNC_BASE;
	logic [7:0]  base_char = 8'd0;
	logic [15:0] read_addr = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kmer_counted;
	logic [15:0] kmer_index;
	logic [15:0] count_value;
	logic        saturated;

	kmer_counting_canonical dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .base_char(base_char), .read_addr(read_addr),
		.out_valid(out_valid), .out_ready(out_ready),
		.kmer_counted(kmer_counted), .kmer_index(kmer_index),
		.count_value(count_value), .saturated(saturated)
	);

	always #4 clk = ~clk;

	char_item_t   chars_to_send [$];
	kmer_result_t counts_due [$];
	int unsigned  send_idle = 0;
	int unsigned  recv_stall = 0;
	int unsigned  mismatches = 0;
	logic         in_taken = 1'b0;

	// Model state of the counter.
	logic [3:0]   len_cfg = kcc_pkg::KMER_LEN_RESET;
	logic         canon_cfg = kcc_pkg::CANONICAL_RESET;
	logic [31:0]  fwd_win = '0;
	logic [31:0]  rc_win = '0;
	int unsigned  bases_held = 0;
	bit   [15:0]  counts [0:65535];

	function automatic char_item_t make_item(input logic fn, input logic [7:0] ch,
			input logic [15:0] addr);
		char_item_t it;
		it.fn = fn;
		it.ch = ch;
		it.addr = addr;
		it.hold = 1'b0;
		return it;
	endfunction

	function automatic kmer_result_t count_step(input char_item_t it);
		kmer_result_t r;
		int unsigned  k;
		logic [1:0]   code;
		logic [1:0]   comp;
		logic [31:0]  mask;
		logic [15:0]  idx;
		bit           is_base;
		r = '0;
		if (it.fn == kcc_pkg::FUNC_READ) begin
			r.count = counts[it.addr];
			return r;
		end
		is_base = 1'b1;
		code = kcc_pkg::BASE_A;
		case (it.ch)
			kcc_pkg::CHAR_A: code = kcc_pkg::BASE_A;
			kcc_pkg::CHAR_C: code = kcc_pkg::BASE_C;
			kcc_pkg::CHAR_G: code = kcc_pkg::BASE_G;
			kcc_pkg::CHAR_T: code = kcc_pkg::BASE_T;
			default: is_base = 1'b0;
		endcase
		if (!is_base) begin
			fwd_win = '0;
			rc_win = '0;
			bases_held = 0;
			return r;
		end
		k = (len_cfg == 0) ? 1 : (len_cfg > kcc_pkg::MAX_K) ? kcc_pkg::MAX_K : len_cfg;
		mask = (32'd1 << (2 * k)) - 32'd1;
		comp = ~code;
		fwd_win = ((fwd_win << 2) | {30'd0, code}) & mask;
		rc_win = ((rc_win & mask) >> 2) | ({30'd0, comp} << (2 * (k - 1)));
		if (bases_held < k)
			bases_held++;
		if (bases_held < k)
			return r;
		idx = fwd_win[15:0];
		if (canon_cfg && rc_win < fwd_win)
			idx = rc_win[15:0];
		r.counted = 1'b1;
		r.index = idx;
		r.sat = (counts[idx] == kcc_pkg::COUNT_MAX);
		if (!r.sat)
			counts[idx]++;
		r.count = counts[idx];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : watch
		kmer_result_t got;
		kmer_result_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				got = {kmer_counted, kmer_index, count_value, saturated};
				if (counts_due.size() == 0) begin
					$display("%0t ns: result with none outstanding, expected nothing, got %h",
						$time, got);
					mismatches++;
				end else begin
					want = counts_due.pop_front();
					check_field("kmer_counted", 16'(want.counted), 16'(got.counted));
					check_field("kmer_index", want.index, got.index);
					check_field("count_value", want.count, got.count);
					check_field("saturated", 16'(want.sat), 16'(got.sat));
				end
			end
			if (in_valid && in_ready)
				counts_due.push_back(count_step(make_item(func, base_char, read_addr)));
		end
	end

	always @(negedge clk) begin : drive
		char_item_t cur;
		if (!in_valid || in_taken) begin
			if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle
					&& !(chars_to_send[0].hold && counts_due.size() != 0)) begin
				cur = chars_to_send.pop_front();
				in_valid <= 1'b1;
				func <= cur.fn;
				base_char <= cur.ch;
				read_addr <= cur.addr;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	task automatic push_bases(input string s);
		for (int i = 0; i < s.len(); i++)
			chars_to_send.push_back(make_item(kcc_pkg::FUNC_BASE, s[i], 16'($urandom)));
	endtask

	task automatic push_read(input logic [15:0] addr);
		chars_to_send.push_back(make_item(kcc_pkg::FUNC_READ, 8'($urandom), addr));
	endtask

	// Mostly whole reads of random bases, with table reads and stray characters mixed in.
	task automatic queue_random(input int n);
		int added;
		int len;
		char_item_t it;
		added = 0;
		while (added < n) begin
			case ($urandom_range(99) / 15)
				0, 1, 2, 3: begin
					len = $urandom_range(1, 24);
					for (int i = 0; i < len; i++) begin
						it = make_item(kcc_pkg::FUNC_BASE, DNA_CHARS[$urandom_range(3)],
							16'($urandom));
						it.hold = ($urandom_range(59) == 0);
						chars_to_send.push_back(it);
					end
					added += len;
					if ($urandom_range(9) < 8) begin
						chars_to_send.push_back(make_item(kcc_pkg::FUNC_BASE, CHAR_NL,
							16'($urandom)));
						added++;
					end
				end
				5: begin
					chars_to_send.push_back(make_item(kcc_pkg::FUNC_BASE, 8'($urandom),
						16'($urandom)));
					added++;
				end
				default: begin
					push_read($urandom_range(1) ? 16'($urandom_range(255)) : 16'($urandom));
					added++;
				end
			endcase
		end
	endtask

	task automatic wait_idle();
		while (chars_to_send.size() != 0 || in_valid || counts_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == kcc_pkg::REG_KMER_LEN)
			len_cfg = data;
		else
			canon_cfg = data[0];
	endtask

	initial begin
		logic [3:0]  lens [8];
		bit          modes [8];
		int unsigned idles [4];
		int unsigned stalls [4];
		lens = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd5, 4'd15, 4'd3, 4'd4};
		modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		idles = '{0, 68, 0, 20};
		stalls = '{0, 0, 68, 20};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_bases("ACGTACGT");
		chars_to_send.push_back(make_item(kcc_pkg::FUNC_BASE, 8'h00, 16'hFFFF));
		chars_to_send.push_back(make_item(kcc_pkg::FUNC_BASE, 8'hFF, 16'h0000));
		chars_to_send.push_back(make_item(kcc_pkg::FUNC_BASE, CHAR_NL, 16'h5A5A));
		push_read(16'h1B1B);
		wait_idle();
		write_reg(kcc_pkg::REG_KMER_LEN, 4'd15);
		write_reg(kcc_pkg::REG_CANONICAL, 4'd0);
		push_bases("TTTTTTTT");
		push_read(16'hFFFF);
		wait_idle();
		write_reg(kcc_pkg::REG_KMER_LEN, 4'd0);
		push_bases("GAC\n");
		wait_idle();
		write_reg(kcc_pkg::REG_KMER_LEN, 4'd4);
		write_reg(kcc_pkg::REG_CANONICAL, 4'd1);
		push_bases("CCG");
		wait_idle();
		write_reg(kcc_pkg::REG_KMER_LEN, 4'd2);
		push_bases("T");
		push_read(16'h0006);

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			write_reg(kcc_pkg::REG_KMER_LEN, lens[p]);
			write_reg(kcc_pkg::REG_CANONICAL, {3'b000, modes[p]});
			send_idle = idles[p % 4];
			recv_stall = stalls[p % 4];
			queue_random(110);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("kmer_counting_canonical_tb: PASS");
		else
			$display("kmer_counting_canonical_tb: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("kmer_counting_canonical_tb: FAIL");
		$finish;
	end

endmodule
